[sv/uoi_pkg.sv]
// shared types, codes and constants for the unicycle odometry integrator
// no dependencies; imported by every module of the block
package uoi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 30;
    localparam int TRIG_W           = 34;   // cordic x/y Q2.30 with headroom; z is the angle, 2^32 per turn
    localparam int MUL_A_W          = 49;
    localparam int MUL_B_W          = 17;
    localparam int MUL_P_W          = MUL_A_W + MUL_B_W;

    localparam logic [31:0]       TIMEOUT_RST  = 32'd32768;
    localparam logic [TRIG_W-1:0] CORDIC_START = TRIG_W'(652032874);

    typedef enum logic [1:0] {
        REQ_CMD  = 2'd0,
        REQ_POSE = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MUL_TH,     // angular velocity times dt
        MUL_VD,     // linear velocity times dt
        MUL_XC,     // v*dt times cosine
        MUL_YS      // v*dt times sine
    } t_mul_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AGE,
        S_MTH,
        S_HEAD,
        S_VD,
        S_CORD,
        S_FIX,
        S_MX,
        S_MY,
        S_AY,
        S_OUT
    } t_state;

    typedef struct packed {
        logic     load_cmd;
        logic     load_pose;
        logic     load_dt;
        logic     age_upd;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     head_upd;
        logic     vd_load;
        logic     cordic_init;
        logic     cordic_step;
        logic     trig_fix;
        logic     x_upd;
        logic     y_upd;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic cordic_last;
        logic out_busy;
    } t_status;

    function automatic logic [TRIG_W-1:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return {{(TRIG_W-32){1'b0}}, v};
    endfunction

endpackage

[sv/uoi_ctrl.sv]
// sequencer for the odometry integrator: walks a tick through age check,
// heading update, cordic iterations and position update; uses uoi_pkg
module uoi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_req_type,
    input  uoi_pkg::t_status i_status,
    output uoi_pkg::t_cmd   o_cmd
);
    import uoi_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign w_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && i_req_type == REQ_TICK) n_state = S_AGE;
            end
            S_AGE:  n_state = S_MTH;
            S_MTH:  n_state = S_HEAD;
            S_HEAD: n_state = S_VD;
            S_VD:   n_state = S_CORD;
            S_CORD: begin
                if (i_status.cordic_last) n_state = S_FIX;
            end
            S_FIX:  n_state = S_MX;
            S_MX:   n_state = S_MY;
            S_MY:   n_state = S_AY;
            S_AY:   n_state = S_OUT;
            S_OUT: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_TH;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_cmd  = w_acc && i_req_type == REQ_CMD;
                o_cmd.load_pose = w_acc && i_req_type == REQ_POSE;
                o_cmd.load_dt   = w_acc && i_req_type == REQ_TICK;
            end
            S_AGE: o_cmd.age_upd = 1'b1;
            S_MTH: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_TH;
            end
            S_HEAD: begin
                o_cmd.head_upd = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_VD;
            end
            S_VD: begin
                o_cmd.vd_load     = 1'b1;
                o_cmd.cordic_init = 1'b1;
            end
            S_CORD: o_cmd.cordic_step = 1'b1;
            S_FIX:  o_cmd.trig_fix = 1'b1;
            S_MX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_XC;
            end
            S_MY: begin
                o_cmd.x_upd   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_YS;
            end
            S_AY:  o_cmd.y_upd = 1'b1;
            S_OUT: o_cmd.out_load = !i_status.out_busy;
            default: ;
        endcase
    end

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req_type == REQ_TICK) |=> r_state == S_AGE)
        else $error("tick item did not start the sequence");
    a_cordic_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORD && !i_status.cordic_last) |=> r_state == S_CORD)
        else $error("cordic left early");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("ready while a tick is in flight");

endmodule

[sv/uoi_datapath.sv]
// pose and velocity state, shared multiplier, iterative cordic and the
// result register of the odometry integrator; uses uoi_pkg
module uoi_datapath #(
    parameter int CORDIC_STEPS = uoi_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  uoi_pkg::t_cmd      i_cmd,
    output uoi_pkg::t_status   o_status,
    input  logic signed [31:0] i_cmd_linear,
    input  logic signed [31:0] i_cmd_angular,
    input  logic signed [31:0] i_new_x,
    input  logic signed [31:0] i_new_y,
    input  logic signed [31:0] i_new_heading,
    input  logic [15:0]        i_delta_time,
    input  logic [31:0]        i_timeout,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_heading,
    output logic               o_timed_out
);
    import uoi_pkg::*;

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic signed [31:0] r_x, r_y, r_lin, r_ang;
    logic [31:0]        r_head, r_age;
    logic [15:0]        r_dt;
    logic               r_tout;
    logic signed [MUL_P_W-1:0] r_prod;
    logic signed [MUL_A_W-1:0] r_vd;
    logic signed [TRIG_W-1:0]  r_cx, r_cy, r_cz;
    logic [IW-1:0]      r_i;
    logic               r_flip;
    logic signed [16:0] r_cos, r_sin;
    logic               r_out_valid;
    logic signed [31:0] r_ox, r_oy, r_oh;
    logic               r_ot;

    logic [32:0]               w_age_sum;
    logic [31:0]               w_age;
    logic signed [MUL_A_W-1:0] w_ma;
    logic signed [MUL_B_W-1:0] w_mb;
    logic                      w_flip;
    logic [31:0]               w_fold;
    logic signed [TRIG_W-1:0]  w_dx, w_dy, w_atan;
    logic signed [34:0]        w_inc;

    function automatic logic signed [16:0] to_q15(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = (v + 36'sd16384) >>> 15;
        if (r > 36'sd32767) return 17'sd32767;
        if (r < -36'sd32768) return -17'sd32768;
        return r[16:0];
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                   input logic signed [34:0] d);
        logic signed [35:0] s;
        s = 36'(p) + 36'(d);
        if (s > 36'sd2147483647) return 32'sh7fffffff;
        if (s < -36'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    assign w_age_sum = {1'b0, r_age} + {17'd0, r_dt};
    assign w_age     = w_age_sum[32] ? 32'hffffffff : w_age_sum[31:0];

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_TH: begin
                w_ma = MUL_A_W'(r_ang);
                w_mb = {1'b0, r_dt};
            end
            MUL_VD: begin
                w_ma = MUL_A_W'(r_lin);
                w_mb = {1'b0, r_dt};
            end
            MUL_XC: begin
                w_ma = r_vd;
                w_mb = r_cos;
            end
            MUL_YS: begin
                w_ma = r_vd;
                w_mb = r_sin;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // fold into [-pi/2, pi/2) by a half turn
    assign w_flip = r_head[31] ^ r_head[30];
    assign w_fold = {r_head[31] ^ w_flip, r_head[30:0]};

    assign w_dx   = r_cy >>> r_i;
    assign w_dy   = r_cx >>> r_i;
    assign w_atan = atan_lut(5'(r_i));
    assign w_inc  = r_prod[MUL_P_W-1:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x   <= '0;
            r_y   <= '0;
            r_head <= '0;
            r_lin <= '0;
            r_ang <= '0;
            r_age <= 32'hffffffff;
        end else begin
            if (i_cmd.load_cmd) begin
                r_lin <= i_cmd_linear;
                r_ang <= i_cmd_angular;
                r_age <= '0;
            end
            if (i_cmd.load_pose) begin
                r_x    <= i_new_x;
                r_y    <= i_new_y;
                r_head <= i_new_heading;
            end
            if (i_cmd.age_upd) begin
                r_age <= w_age;
                if (w_age > i_timeout) begin
                    r_lin <= '0;
                    r_ang <= '0;
                end
            end
            if (i_cmd.head_upd) r_head <= r_head + r_prod[39:8];
            if (i_cmd.x_upd) r_x <= sat_add(r_x, w_inc);
            if (i_cmd.y_upd) r_y <= sat_add(r_y, w_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_dt) r_dt <= i_delta_time;
        if (i_cmd.age_upd) r_tout <= (w_age > i_timeout);
        if (i_cmd.mul_en) r_prod <= w_ma * w_mb;
        if (i_cmd.vd_load) r_vd <= r_prod[MUL_A_W-1:0];
        if (i_cmd.cordic_init) begin
            r_cx   <= CORDIC_START;
            r_cy   <= '0;
            r_cz   <= TRIG_W'(signed'(w_fold));
            r_i    <= '0;
            r_flip <= w_flip;
        end else if (i_cmd.cordic_step) begin
            if (!r_cz[TRIG_W-1]) begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_atan;
            end
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.trig_fix) begin
            r_cos <= to_q15(r_flip ? -36'(r_cx) : 36'(r_cx));
            r_sin <= to_q15(r_flip ? -36'(r_cy) : 36'(r_cy));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ox <= r_x;
            r_oy <= r_y;
            r_oh <= r_head;
            r_ot <= r_tout;
        end
    end

    assign o_status.cordic_last = (r_i == IW'(CORDIC_STEPS - 1));
    assign o_status.out_busy    = r_out_valid && !i_ready;
    assign o_valid     = r_out_valid;
    assign o_pos_x     = r_ox;
    assign o_pos_y     = r_oy;
    assign o_heading   = r_oh;
    assign o_timed_out = r_ot;

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && !i_cmd.out_load) |=> $stable(r_ox) && $stable(r_oy))
        else $error("pending result changed");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && !i_ready))
        else $error("result overwritten before it was taken");
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.age_upd && w_age > i_timeout) |=> (r_lin == 32'sd0 && r_ang == 32'sd0))
        else $error("velocities not cleared on timeout");

endmodule

[sv/unicycle_odometry_integrator_core.sv]
// top level of the unicycle odometry integrator: apb timeout register,
// sequencer and datapath; uses uoi_pkg, uoi_ctrl, uoi_datapath
// command and pose items are loaded on accept; a tick walks the age, heading,
// cordic, fix and position states before the result register is loaded
// one tick at a time: ready only when idle, and a tick waits while a result is pending
// reset (synchronous, active low): pose and velocities zero, command age all ones
module unicycle_odometry_integrator_core #(
    parameter int CORDIC_STEPS = uoi_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_cmd_linear,
    input  logic signed [31:0] i_cmd_angular,
    input  logic signed [31:0] i_new_x,
    input  logic signed [31:0] i_new_y,
    input  logic signed [31:0] i_new_heading,
    input  logic [15:0]        i_delta_time,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_heading,
    output logic               o_timed_out
);
    import uoi_pkg::*;

    logic [31:0] r_timeout;
    t_cmd        w_cmd;
    t_status     w_status;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_timeout <= pwdata;
        end
    end

    uoi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    uoi_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cmd_linear  (i_cmd_linear),
        .i_cmd_angular (i_cmd_angular),
        .i_new_x       (i_new_x),
        .i_new_y       (i_new_y),
        .i_new_heading (i_new_heading),
        .i_delta_time  (i_delta_time),
        .i_timeout     (r_timeout),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_heading     (o_heading),
        .o_timed_out   (o_timed_out)
    );

endmodule
